// File: rtl/srrw_pkg.sv
// shared constants, codes and types of the selective-repeat receive window
package srrw_pkg;

    // ring and field sizes
    localparam int RING_SLOTS    = 64;
    localparam int SLOT_BITS     = $clog2(RING_SLOTS);
    localparam int PAYLOAD_BITS  = 32;
    localparam int SEQ_BITS      = 8;
    localparam int WSIZE_BITS    = 6;
    localparam int ATTEMPT_BITS  = 8;
    localparam int KIND_BITS     = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

    // register reset values
    localparam logic [WSIZE_BITS-1:0]   WSIZE_RESET   = WSIZE_BITS'(16);
    localparam logic [ATTEMPT_BITS-1:0] ATTEMPT_RESET = ATTEMPT_BITS'(10);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ATTEMPTS = CFG_IDX_BITS'(1);

    // input operation codes
    localparam logic OP_PACKET  = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // result kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_ACK     = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_FINAL   = 2'd2,
        KIND_ABORT   = 2'd3
    } srrw_kind_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ACK,
        BK_READ,
        BK_LOAD,
        BK_DELIV
    } srrw_back_state_t;

    // command from the classifier to the back end
    typedef struct packed {
        srrw_kind_t              kind;
        logic [SEQ_BITS-1:0]     seq;
        logic                    no_seq;
        logic                    store;
        logic                    drain;
        logic [PAYLOAD_BITS-1:0] payload;
    } srrw_cmd_t;

    // slot status seen by the classifier
    typedef struct packed {
        logic [SLOT_BITS-1:0]  base;
        logic [RING_SLOTS-1:0] full;
        logic                  store_done;
    } srrw_slot_stat_t;

endpackage

// File: rtl/srrw_if.sv
// handshake channel interfaces: packet items, results and register writes
interface srrw_in_if;
    import srrw_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [SEQ_BITS-1:0]     seq;
    logic [PAYLOAD_BITS-1:0] payload;
    modport source (output valid, output op, output seq, output payload, input ready);
    modport sink   (input valid, input op, input seq, input payload, output ready);
endinterface

interface srrw_out_if;
    import srrw_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [KIND_BITS-1:0]    kind;
    logic [SEQ_BITS-1:0]     seq_out;
    logic                    no_seq;
    logic [PAYLOAD_BITS-1:0] data_out;
    logic                    last;
    modport source (output valid, output kind, output seq_out, output no_seq,
                    output data_out, output last, input ready);
    modport sink   (input valid, input kind, input seq_out, input no_seq,
                    input data_out, input last, output ready);
endinterface

interface srrw_cfg_if;
    import srrw_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/srrw_ram.sv
// generic single write port ram with registered read
module srrw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/srrw_front.sv
// front end: register writes, item acceptance, window and timeout classification
module srrw_front (
    input  logic                      clk,
    input  logic                      rst_n,
    srrw_in_if.sink                   item,
    srrw_cfg_if.sink                  cfg,
    input  srrw_pkg::srrw_slot_stat_t stat,
    input  logic                      q_full,
    output logic                      q_push,
    output srrw_pkg::srrw_cmd_t       q_cmd
);
    import srrw_pkg::*;

    logic [WSIZE_BITS-1:0]   wsize_reg, wsize_next;
    logic [ATTEMPT_BITS-1:0] max_att_reg, max_att_next;
    logic [ATTEMPT_BITS-1:0] tcount_reg, tcount_next;
    logic [SEQ_BITS-1:0]     last_seq_reg, last_seq_next;
    logic                    seen_reg, seen_next;
    logic                    fin_reg, fin_next;
    logic                    pend_reg, pend_next;

    logic                    accept;
    logic [SLOT_BITS-1:0]    slot_idx;
    logic                    is_final;
    logic [SLOT_BITS:0]      off_wide;
    logic [SLOT_BITS:0]      off;
    logic [SLOT_BITS:0]      w_eff;
    logic                    in_win;
    logic                    do_store;

    // stall while a storing packet is still being worked off in the back end, or on a full queue before the end
    assign item.ready = !pend_reg && (fin_reg || !q_full);
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;

    // window position of the incoming sequence number
    always_comb
    begin
        slot_idx = item.seq[SLOT_BITS-1:0];
        is_final = int'(item.seq) >= RING_SLOTS;
        off_wide = {1'b0, slot_idx} + (SLOT_BITS+1)'(RING_SLOTS) - {1'b0, stat.base};
        off      = (int'(off_wide) >= RING_SLOTS)
                   ? off_wide - (SLOT_BITS+1)'(RING_SLOTS) : off_wide;
        w_eff    = (int'(wsize_reg) >= RING_SLOTS)
                   ? (SLOT_BITS+1)'(RING_SLOTS - 1) : (SLOT_BITS+1)'(wsize_reg);
        in_win   = off < w_eff;
        do_store = in_win && !stat.full[slot_idx];
    end

    // classification and state update
    always_comb
    begin
        wsize_next    = wsize_reg;
        max_att_next  = max_att_reg;
        tcount_next   = tcount_reg;
        last_seq_next = last_seq_reg;
        seen_next     = seen_reg;
        fin_next      = fin_reg;
        pend_next     = pend_reg;
        q_push        = 1'b0;
        q_cmd.kind    = KIND_ACK;
        q_cmd.seq     = '0;
        q_cmd.no_seq  = 1'b0;
        q_cmd.store   = 1'b0;
        q_cmd.drain   = 1'b0;
        q_cmd.payload = item.payload;

        if (stat.store_done)
        begin
            pend_next = 1'b0;
        end

        if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_WINDOW_SIZE)
            begin
                wsize_next = cfg.data[WSIZE_BITS-1:0];
            end
            else if (cfg.index == REG_MAX_ATTEMPTS)
            begin
                max_att_next = cfg.data[ATTEMPT_BITS-1:0];
            end
        end

        if (accept && !fin_reg)
        begin
            q_push = 1'b1;
            if (item.op == OP_TIMEOUT)
            begin
                if (tcount_reg < max_att_reg)
                begin
                    tcount_next  = tcount_reg + ATTEMPT_BITS'(1);
                    q_cmd.kind   = KIND_ACK;
                    q_cmd.seq    = seen_reg ? last_seq_reg : '0;
                    q_cmd.no_seq = !seen_reg;
                end
                else
                begin
                    fin_next   = 1'b1;
                    q_cmd.kind = KIND_ABORT;
                end
            end
            else
            begin
                tcount_next   = '0;
                last_seq_next = item.seq;
                seen_next     = 1'b1;
                q_cmd.seq     = item.seq;
                if (is_final)
                begin
                    fin_next   = 1'b1;
                    q_cmd.kind = KIND_FINAL;
                end
                else
                begin
                    q_cmd.kind  = KIND_ACK;
                    q_cmd.store = do_store;
                    q_cmd.drain = do_store && (slot_idx == stat.base);
                    pend_next   = do_store;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg    <= WSIZE_RESET;
            max_att_reg  <= ATTEMPT_RESET;
            tcount_reg   <= '0;
            last_seq_reg <= '0;
            seen_reg     <= 1'b0;
            fin_reg      <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            wsize_reg    <= wsize_next;
            max_att_reg  <= max_att_next;
            tcount_reg   <= tcount_next;
            last_seq_reg <= last_seq_next;
            seen_reg     <= seen_next;
            fin_reg      <= fin_next;
            pend_reg     <= pend_next;
        end
    end
endmodule

// File: rtl/srrw_cmd_queue.sv
// short command queue between the front end and the back end
module srrw_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srrw_pkg::srrw_cmd_t push_cmd,
    input  logic                pop,
    output logic                head_valid,
    output srrw_pkg::srrw_cmd_t head_cmd,
    output logic                full
);
    import srrw_pkg::*;

    srrw_cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]     count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign head_valid = count_reg != '0;
    assign full       = int'(count_reg) == QUEUE_DEPTH;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1)
                          ? '0 : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1)
                          ? '0 : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_BITS+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_BITS+1)'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

// File: rtl/srrw_back.sv
// back end: slot store, in-order drain and result output register
module srrw_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  srrw_pkg::srrw_cmd_t       q_cmd,
    output logic                      q_pop,
    output srrw_pkg::srrw_slot_stat_t stat,
    srrw_out_if.source                result
);
    import srrw_pkg::*;

    srrw_back_state_t        state_reg, state_next;
    logic [SLOT_BITS-1:0]    base_reg, base_next;
    logic [RING_SLOTS-1:0]   full_reg, full_next;
    logic                    store_reg, drain_reg;
    logic                    out_valid_reg, out_valid_next;
    srrw_kind_t              out_kind_reg;
    logic [SEQ_BITS-1:0]     out_seq_reg;
    logic                    out_no_seq_reg;
    logic [PAYLOAD_BITS-1:0] out_data_reg;
    logic                    out_last_reg;

    logic                    taken;
    logic                    load_ack;
    logic                    load_deliv;
    logic                    ram_we;
    logic                    store_done;
    logic [SLOT_BITS-1:0]    base_inc;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    assign taken    = out_valid_reg && result.ready;
    assign base_inc = (int'(base_reg) == RING_SLOTS - 1) ? '0 : base_reg + SLOT_BITS'(1);

    // payload store, read at the window base
    srrw_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (RING_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_cmd.seq[SLOT_BITS-1:0]),
        .wdata (q_cmd.payload),
        .raddr (base_reg),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_ACK;
                end
            end
            BK_ACK:
            begin
                if (taken)
                begin
                    state_next = drain_reg ? BK_READ : BK_IDLE;
                end
            end
            BK_READ:
            begin
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                state_next = BK_DELIV;
            end
            BK_DELIV:
            begin
                if (taken)
                begin
                    state_next = out_last_reg ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop      = 1'b0;
        load_ack   = 1'b0;
        load_deliv = 1'b0;
        ram_we     = 1'b0;
        store_done = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop    = q_valid;
                load_ack = q_valid;
                ram_we   = q_valid && q_cmd.store;
            end
            BK_ACK:
            begin
                store_done = taken && store_reg && !drain_reg;
            end
            BK_LOAD:
            begin
                load_deliv = 1'b1;
            end
            BK_DELIV:
            begin
                store_done = taken && out_last_reg;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // slot flags, base and output valid
    always_comb
    begin
        base_next      = base_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        if (taken)
        begin
            out_valid_next = 1'b0;
        end
        if (ram_we)
        begin
            full_next[q_cmd.seq[SLOT_BITS-1:0]] = 1'b1;
        end
        if (load_deliv)
        begin
            full_next[base_reg] = 1'b0;
            base_next           = base_inc;
        end
        if (load_ack || load_deliv)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            base_reg      <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result beat and command flags
    always_ff @(posedge clk)
    begin
        if (load_ack)
        begin
            store_reg      <= q_cmd.store;
            drain_reg      <= q_cmd.drain;
            out_kind_reg   <= q_cmd.kind;
            out_seq_reg    <= q_cmd.seq;
            out_no_seq_reg <= q_cmd.no_seq;
            out_data_reg   <= '0;
            out_last_reg   <= !q_cmd.drain;
        end
        else if (load_deliv)
        begin
            out_kind_reg   <= KIND_DELIVER;
            out_seq_reg    <= SEQ_BITS'(base_reg);
            out_no_seq_reg <= 1'b0;
            out_data_reg   <= ram_rdata;
            out_last_reg   <= !full_reg[base_inc];
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.kind     = out_kind_reg;
    assign result.seq_out  = out_seq_reg;
    assign result.no_seq   = out_no_seq_reg;
    assign result.data_out = out_data_reg;
    assign result.last     = out_last_reg;

    assign stat.base       = base_reg;
    assign stat.full       = full_reg;
    assign stat.store_done = store_done;
endmodule

// File: rtl/selective_repeat_receive_window_unit.sv
// top level of the selective-repeat receive window
//
//  channel  dir  beat contents                         accepted when
//  item     in   op, seq, payload                      item.valid & item.ready
//  result   out  kind, seq_out, no_seq, data_out, last result.valid & result.ready
//  cfg      in   index, data                           cfg.valid (ready always high)
//
// an ack, final or abort beat is popped from the queue head in BK_IDLE and registered for output;
// each delivered slot passes BK_READ (slot ram read), BK_LOAD (load) and BK_DELIV (present).
// a packet that is stored holds item.ready low until its ack and all deliveries are taken;
// other items only wait for a free entry in the 4-deep command queue.
// slot flags are flip-flops cleared by rst_n, so no clearing pass follows reset.
// a stall on result backs up into the queue and then into item.ready.
module selective_repeat_receive_window_unit (
    input  logic       clk,
    input  logic       rst_n,
    srrw_in_if.sink    item,
    srrw_cfg_if.sink   cfg,
    srrw_out_if.source result
);
    import srrw_pkg::*;

    srrw_cmd_t       push_cmd;
    srrw_cmd_t       head_cmd;
    srrw_slot_stat_t stat;
    logic            push;
    logic            pop;
    logic            head_valid;
    logic            q_full;

    // classification
    srrw_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .stat   (stat),
        .q_full (q_full),
        .q_push (push),
        .q_cmd  (push_cmd)
    );

    // decoupling queue
    srrw_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (q_full)
    );

    // store, drain and output
    srrw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (head_valid),
        .q_cmd   (head_cmd),
        .q_pop   (pop),
        .stat    (stat),
        .result  (result)
    );
endmodule

// File: rtl/srrw_checker.sv
// port-level checks on the result channel, bound to the top level
module srrw_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [srrw_pkg::KIND_BITS-1:0]    res_kind,
    input logic [srrw_pkg::SEQ_BITS-1:0]     res_seq_out,
    input logic                              res_no_seq,
    input logic [srrw_pkg::PAYLOAD_BITS-1:0] res_data_out,
    input logic                              res_last
);
    import srrw_pkg::*;

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind)
            && $stable(res_seq_out) && $stable(res_data_out) && $stable(res_last))
        else $error("result beat changed while stalled");

    // only deliveries carry data
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_DELIVER |-> res_data_out == '0)
        else $error("non-delivery beat carries data");

    // final and abort end the item, abort names no sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_FINAL || res_kind == KIND_ABORT) |-> res_last
            && !res_no_seq && (res_kind == KIND_FINAL || res_seq_out == '0))
        else $error("bad final or abort beat");

    // no-sequence flag only on an ack that ends its item
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_no_seq |-> res_kind == KIND_ACK && res_last && res_seq_out == '0)
        else $error("no_seq on a wrong beat");
endmodule

bind selective_repeat_receive_window_unit srrw_checker u_srrw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_kind     (result.kind),
    .res_seq_out  (result.seq_out),
    .res_no_seq   (result.no_seq),
    .res_data_out (result.data_out),
    .res_last     (result.last)
);

// File: tb/tb_selective_repeat_receive_window_unit.sv
// testbench for the selective-repeat receive window: predicted results checked beat by beat
`timescale 1ns / 100ps

module tb_selective_repeat_receive_window_unit;
    import srrw_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_BURST     = 64;

    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(3);

    // one expected result beat
    typedef struct {
        srrw_kind_t              kind;
        logic [SEQ_BITS-1:0]     seq_out;
        logic                    no_seq;
        logic [PAYLOAD_BITS-1:0] data_out;
        logic                    last;
    } window_beat_t;

    // receive window state, expected beats and checking
    class arq_window_checker;
        logic [WSIZE_BITS-1:0]   wsize;
        logic [ATTEMPT_BITS-1:0] max_attempts;
        bit                      full [RING_SLOTS];
        logic [PAYLOAD_BITS-1:0] slot_data [RING_SLOTS];
        logic [SLOT_BITS-1:0]    base;
        logic [SEQ_BITS-1:0]     last_seq;
        bit                      seen_any;
        logic [ATTEMPT_BITS-1:0] timeouts;
        bit                      done;
        window_beat_t            pending [$];
        int                      errors;

        function new();
            wsize        = WSIZE_RESET;
            max_attempts = ATTEMPT_RESET;
            foreach (full[i])
                full[i] = 1'b0;
            base     = '0;
            last_seq = '0;
            seen_any = 1'b0;
            timeouts = '0;
            done     = 1'b0;
            errors   = 0;
        endfunction

        function void note_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            if (idx == REG_WINDOW_SIZE)
                wsize = val[WSIZE_BITS-1:0];
            else if (idx == REG_MAX_ATTEMPTS)
                max_attempts = val[ATTEMPT_BITS-1:0];
        endfunction

        function void push(srrw_kind_t kind, logic [SEQ_BITS-1:0] s, logic ns,
                           logic [PAYLOAD_BITS-1:0] d);
            window_beat_t b;
            b.kind     = kind;
            b.seq_out  = s;
            b.no_seq   = ns;
            b.data_out = d;
            b.last     = 1'b0;
            pending.push_back(b);
        endfunction

        // work out the beats one accepted item causes
        function void take_item(logic op, logic [SEQ_BITS-1:0] seq,
                                logic [PAYLOAD_BITS-1:0] payload);
            int                   first;
            logic [SLOT_BITS-1:0] slot;
            logic [SLOT_BITS-1:0] off;
            first = pending.size();
            if (done)
                return;
            if (op == OP_TIMEOUT)
            begin
                if (timeouts < max_attempts)
                begin
                    timeouts++;
                    push(KIND_ACK, seen_any ? last_seq : '0, !seen_any, '0);
                end
                else
                begin
                    done = 1'b1;
                    push(KIND_ABORT, '0, 1'b0, '0);
                end
            end
            else
            begin
                timeouts = '0;
                last_seq = seq;
                seen_any = 1'b1;
                if (seq >= SEQ_BITS'(RING_SLOTS))
                begin
                    done = 1'b1;
                    push(KIND_FINAL, seq, 1'b0, '0);
                end
                else
                begin
                    slot = seq[SLOT_BITS-1:0];
                    off  = slot - base;
                    push(KIND_ACK, seq, 1'b0, '0);
                    // store when inside the window and not a duplicate
                    if (off < wsize && !full[slot])
                    begin
                        full[slot]      = 1'b1;
                        slot_data[slot] = payload;
                        // in-order drain from the base
                        if (slot == base)
                        begin
                            while (pending.size() - first < MAX_BURST && full[base])
                            begin
                                push(KIND_DELIVER, SEQ_BITS'(base), 1'b0, slot_data[base]);
                                full[base] = 1'b0;
                                base++;
                            end
                        end
                    end
                end
            end
            if (pending.size() > first)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        // compare one result beat with the oldest expectation
        function void check_beat(logic [KIND_BITS-1:0] kind, logic [SEQ_BITS-1:0] seq_out,
                                 logic no_seq, logic [PAYLOAD_BITS-1:0] data_out,
                                 logic last);
            window_beat_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: kind %0d seq_out %0d data_out %h",
                       kind, seq_out, data_out);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (seq_out !== e.seq_out)
            begin
                $error("seq_out: expected %0d, actual %0d", e.seq_out, seq_out);
                errors++;
            end
            if (no_seq !== e.no_seq)
            begin
                $error("no_seq: expected %0b, actual %0b", e.no_seq, no_seq);
                errors++;
            end
            if (data_out !== e.data_out)
            begin
                $error("data_out: expected %h, actual %h", e.data_out, data_out);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0b, actual %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    srrw_in_if  pkt_bus ();
    srrw_cfg_if cfg_bus ();
    srrw_out_if res_bus ();

    arq_window_checker sb;

    int src_idle_pct;
    int snk_stall_pct;
    bit hold_req;
    int quiet_cycles;

    selective_repeat_receive_window_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (pkt_bus.sink),
        .cfg    (cfg_bus.sink),
        .result (res_bus.source)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one item, note it once accepted
    task automatic send_item(input logic op, input logic [SEQ_BITS-1:0] seq,
                             input logic [PAYLOAD_BITS-1:0] payload);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pkt_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_bus.valid   <= 1'b1;
        pkt_bus.op      <= op;
        pkt_bus.seq     <= seq;
        pkt_bus.payload <= payload;
        @(posedge clk);
        while (!pkt_bus.ready)
            @(posedge clk);
        sb.take_item(op, seq, payload);
    endtask

    // wait until every expected beat has come, then let the back end settle
    task automatic drain_wait();
        pkt_bus.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // register writes, block idle
    task automatic program_regs(input logic [CFG_DATA_BITS-1:0] ws,
                                input logic [CFG_DATA_BITS-1:0] ma, input bit spare);
        logic [CFG_IDX_BITS-1:0]  idx [3];
        logic [CFG_DATA_BITS-1:0] val [3];
        int                       cnt;
        idx[0] = REG_WINDOW_SIZE;
        idx[1] = REG_MAX_ATTEMPTS;
        idx[2] = REG_SPARE;
        val[0] = ws;
        val[1] = ma;
        val[2] = CFG_DATA_BITS'($urandom);
        cnt = spare ? 3 : 2;
        for (int i = 0; i < cnt; i++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[i];
            cfg_bus.data  <= val[i];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
            sb.note_write(idx[i], val[i]);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // mostly packets around the window base, some timeouts and strays
    task automatic run_random(input int count);
        logic                    op;
        logic [SEQ_BITS-1:0]     seq;
        logic [PAYLOAD_BITS-1:0] payload;
        int                      span;
        for (int i = 0; i < count; i++)
        begin
            payload = $urandom;
            span    = int'(sb.wsize) + 1;
            if (sb.timeouts < sb.max_attempts && $urandom_range(0, 99) < 15)
            begin
                op  = OP_TIMEOUT;
                seq = SEQ_BITS'($urandom_range(0, 255));
            end
            else
            begin
                op = OP_PACKET;
                if ($urandom_range(0, 99) < 80)
                    seq = SEQ_BITS'((int'(sb.base) + $urandom_range(0, span)) % RING_SLOTS);
                else
                    seq = SEQ_BITS'($urandom_range(0, RING_SLOTS - 1));
            end
            send_item(op, seq, payload);
        end
    endtask

    // result sink with random stalls and one long hold-off on request
    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    res_bus.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            res_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
            sb.check_beat(res_bus.kind, res_bus.seq_out, res_bus.no_seq,
                          res_bus.data_out, res_bus.last);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((pkt_bus.valid && pkt_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("selective_repeat_receive_window_unit test failed");
            $finish;
        end
    end

    initial
    begin
        sb              = new();
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        hold_req        = 1'b0;
        quiet_cycles    = 0;
        rst_n           = 1'b0;
        pkt_bus.valid   = 1'b0;
        pkt_bus.op      = OP_PACKET;
        pkt_bus.seq     = '0;
        pkt_bus.payload = '0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = REG_WINDOW_SIZE;
        cfg_bus.data    = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, window of 16 from base 0
        send_item(OP_TIMEOUT, 8'd0, 32'h0);          // no packet seen yet
        send_item(OP_PACKET, 8'd0, 32'h0000_0000);   // at base, delivered at once
        send_item(OP_PACKET, 8'd2, 32'hFFFF_FFFF);   // held behind a gap
        send_item(OP_PACKET, 8'd2, 32'h1234_5678);   // duplicate
        send_item(OP_PACKET, 8'd1, 32'hA5A5_A5A5);   // fills the gap, drains two
        send_item(OP_PACKET, 8'd40, $urandom);       // beyond the window
        send_item(OP_PACKET, 8'd0, $urandom);        // behind the base
        send_item(OP_PACKET, 8'd18, $urandom);       // last slot of the window
        send_item(OP_PACKET, 8'd19, $urandom);       // one past the window
        send_item(OP_TIMEOUT, 8'd255, $urandom);     // re-ack of the last seen
        // fill the window backwards, the base packet drains the lot
        for (int s = 17; s >= 3; s--)
            send_item(OP_PACKET, SEQ_BITS'(s), $urandom);
        run_random(50);
        drain_wait();

        // empty window, sender mostly idle
        program_regs(8'hC0, 8'd255, 1'b0);
        src_idle_pct = 84;
        run_random(50);
        drain_wait();

        // widest window, no timeouts tolerated, receiver mostly stalled
        program_regs(8'hFF, 8'd0, 1'b0);
        src_idle_pct  = 0;
        snk_stall_pct = 84;
        run_random(60);
        drain_wait();

        // single-slot window, both sides idling
        program_regs(8'd1, 8'd3, 1'b1);
        src_idle_pct  = 32;
        snk_stall_pct = 32;
        run_random(60);
        drain_wait();

        // long receiver hold-off with the sender pushing
        program_regs(8'd37, 8'd200, 1'b0);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 1'b1;
        run_random(70);
        drain_wait();

        // closing phase, then end of transfer by final packet or abort
        program_regs(8'd8, 8'd2, 1'b0);
        src_idle_pct  = 32;
        snk_stall_pct = 32;
        run_random(60);
        if ($urandom_range(0, 1) == 1)
            send_item(OP_PACKET, SEQ_BITS'($urandom_range(RING_SLOTS, 255)), $urandom);
        else
            while (!sb.done)
                send_item(OP_TIMEOUT, SEQ_BITS'($urandom_range(0, 255)), $urandom);
        // nothing answers after the end
        for (int i = 0; i < 6; i++)
            send_item(1'($urandom_range(0, 1)), SEQ_BITS'($urandom_range(0, 255)), $urandom);
        drain_wait();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("selective_repeat_receive_window_unit test passed");
        else
            $display("selective_repeat_receive_window_unit test failed");
        $finish;
    end

endmodule

// File: selective_repeat_receive_window_unit.f
rtl/srrw_pkg.sv
rtl/srrw_if.sv
rtl/srrw_ram.sv
rtl/srrw_front.sv
rtl/srrw_cmd_queue.sv
rtl/srrw_back.sv
rtl/selective_repeat_receive_window_unit.sv
rtl/srrw_checker.sv
tb/tb_selective_repeat_receive_window_unit.sv
